FILE: rtl/ftach_pkg.sv
package ftach_pkg;

    localparam int CAPTURE_BITS = 16;
    localparam int CAP_IN_W     = 16;
    localparam int TICK_W       = 20;
    localparam int PPR_W        = 4;
    localparam int TIMEOUT_W    = 16;
    localparam int MS_W         = 17;
    localparam int RPM_W        = 26;
    localparam int DIVISOR_W    = CAPTURE_BITS + PPR_W;
    localparam int DIV_CNT_W    = $clog2(RPM_W);
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 20;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 32;

    localparam logic [MS_W-1:0]      MS_MAX          = {MS_W{1'b1}};
    localparam logic [RPM_W-1:0]     SECONDS_PER_MIN = RPM_W'(60);
    localparam logic [TICK_W-1:0]    TICK_RESET      = TICK_W'(125000);
    localparam logic [PPR_W-1:0]     PPR_RESET       = PPR_W'(2);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = TIMEOUT_W'(1200);

    localparam logic [CFG_ADDR_W-1:0] REG_TICK_RATE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_PPR       = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT   = CFG_ADDR_W'(2);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic emit;
    } ftach_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } ftach_sts_t;

endpackage

FILE: rtl/ftach_ctrl.sv
module ftach_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  ftach_pkg::ftach_sts_t  sts,
    output ftach_pkg::ftach_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.prep     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.emit     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = sts.need_div ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_div_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && sts.div_last) |=> (state_reg == ST_EMIT))
        else $error("divider finished without moving to emit");

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result emitted while output register busy");

    a_load_then_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_PREP))
        else $error("accepted beat not followed by prep");

endmodule

FILE: rtl/ftach_datapath.sv
module ftach_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [ftach_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ftach_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                 opcode,
    input  logic [ftach_pkg::CAP_IN_W-1:0]       capture_value,
    input  ftach_pkg::ftach_cmd_t                cmd,
    output ftach_pkg::ftach_sts_t                sts,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ftach_pkg::RPM_W-1:0]          rpm,
    output logic                                 stalled
);

    localparam int CB  = ftach_pkg::CAPTURE_BITS;
    localparam int DVW = ftach_pkg::DIVISOR_W;
    localparam int RW  = ftach_pkg::RPM_W;
    localparam int MW  = ftach_pkg::MS_W;
    localparam int CW  = ftach_pkg::DIV_CNT_W;

    logic [ftach_pkg::TICK_W-1:0]    tick_rate_reg, tick_rate_next;
    logic [ftach_pkg::PPR_W-1:0]     ppr_reg, ppr_next;
    logic [ftach_pkg::TIMEOUT_W-1:0] timeout_reg, timeout_next;

    logic [CB-1:0]  prev_capture_reg, prev_capture_next;
    logic           first_edge_reg, first_edge_next;
    logic [MW-1:0]  ms_reg, ms_next;
    logic [RW-1:0]  speed_reg, speed_next;

    logic           need_div_reg, need_div_next;
    logic [CB-1:0]  period_reg, period_next;
    logic [DVW-1:0] divisor_reg, divisor_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [RW-1:0]  quot_reg, quot_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    logic           m_valid_reg, m_valid_next;
    logic [RW-1:0]  rpm_reg, rpm_next;
    logic           stalled_reg, stalled_next;

    logic [31:0]              cap_ext;
    logic [CB-1:0]            cap;
    logic [CB-1:0]            period;
    logic [ftach_pkg::PPR_W-1:0] ppr_eff;
    logic [DVW:0]             trial;
    logic [DVW:0]             diff;
    logic                     fits;
    logic                     is_stalled;
    logic                     out_free;

    assign cap_ext  = 32'(capture_value);
    assign cap      = cap_ext[CB-1:0];
    assign period   = cap - prev_capture_reg;
    assign ppr_eff  = (ppr_reg == '0) ? ftach_pkg::PPR_W'(1) : ppr_reg;
    assign trial    = {rem_reg, quot_reg[RW-1]};
    assign diff     = trial - {1'b0, divisor_reg};
    assign fits     = (trial >= {1'b0, divisor_reg});
    assign is_stalled = (ms_reg > MW'(timeout_reg));
    assign out_free = !m_valid_reg || m_tready;

    assign sts.need_div = need_div_reg;
    assign sts.div_last = (cnt_reg == CW'(RW - 1));
    assign sts.out_free = out_free;

    assign m_tvalid = m_valid_reg;
    assign rpm      = rpm_reg;
    assign stalled  = stalled_reg;

    always_comb begin
        tick_rate_next = tick_rate_reg;
        ppr_next       = ppr_reg;
        timeout_next   = timeout_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                ftach_pkg::REG_TICK_RATE: tick_rate_next = cfg_wdata;
                ftach_pkg::REG_PPR:       ppr_next = cfg_wdata[ftach_pkg::PPR_W-1:0];
                ftach_pkg::REG_TIMEOUT:   timeout_next = cfg_wdata[ftach_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prev_capture_next = prev_capture_reg;
        first_edge_next   = first_edge_reg;
        ms_next           = ms_reg;
        speed_next        = speed_reg;
        need_div_next     = need_div_reg;
        period_next       = period_reg;
        divisor_next      = divisor_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        cnt_next          = cnt_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        rpm_next          = rpm_reg;
        stalled_next      = stalled_reg;

        if (cmd.load) begin
            period_next = period;
            if (opcode == ftach_pkg::OP_EDGE) begin
                prev_capture_next = cap;
                first_edge_next   = 1'b0;
                ms_next           = '0;
                need_div_next     = !first_edge_reg && (period != '0);
            end else begin
                need_div_next = 1'b0;
                if (ms_reg != ftach_pkg::MS_MAX) begin
                    ms_next = ms_reg + MW'(1);
                end
            end
        end

        if (cmd.prep) begin
            divisor_next = DVW'(period_reg) * DVW'(ppr_eff);
            quot_next    = RW'(tick_rate_reg) * ftach_pkg::SECONDS_PER_MIN;
            rem_next     = '0;
            cnt_next     = '0;
        end

        if (cmd.div_step) begin
            rem_next  = fits ? diff[DVW-1:0] : trial[DVW-1:0];
            quot_next = {quot_reg[RW-2:0], fits};
            cnt_next  = cnt_reg + CW'(1);
        end

        if (cmd.emit) begin
            if (is_stalled) begin
                speed_next = '0;
            end else if (need_div_reg) begin
                speed_next = quot_reg;
            end
            m_valid_next = 1'b1;
            rpm_next     = is_stalled ? '0 : (need_div_reg ? quot_reg : speed_reg);
            stalled_next = is_stalled;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_rate_reg    <= ftach_pkg::TICK_RESET;
            ppr_reg          <= ftach_pkg::PPR_RESET;
            timeout_reg      <= ftach_pkg::TIMEOUT_RESET;
            prev_capture_reg <= '0;
            first_edge_reg   <= 1'b1;
            ms_reg           <= '0;
            speed_reg        <= '0;
            need_div_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            tick_rate_reg    <= tick_rate_next;
            ppr_reg          <= ppr_next;
            timeout_reg      <= timeout_next;
            prev_capture_reg <= prev_capture_next;
            first_edge_reg   <= first_edge_next;
            ms_reg           <= ms_next;
            speed_reg        <= speed_next;
            need_div_reg     <= need_div_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        period_reg  <= period_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        cnt_reg     <= cnt_next;
        rpm_reg     <= rpm_next;
        stalled_reg <= stalled_next;
    end

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (divisor_reg != '0))
        else $error("divide started with zero divisor");

    a_stall_zero_rpm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && stalled_reg) |-> (rpm_reg == '0))
        else $error("stalled beat carries nonzero rpm");

    a_edge_clears_ms: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && opcode == ftach_pkg::OP_EDGE) |=> (ms_reg == '0 && !first_edge_reg))
        else $error("edge did not clear elapsed count");

endmodule

FILE: rtl/fan_tach_rpm_meter.sv
// Fan tachometer. Each input beat is a one-millisecond tick or a tach edge with its
// captured timer count; every beat yields exactly one result beat with the current rpm
// and the stall flag. Rpm is (tick_rate_hz*60)/(period*pulses_per_rev), worked out by a
// restoring divider at one quotient bit per cycle, run after prep only for an edge that
// needs a new speed; other beats go from prep to emit. An output register holds the
// result, so the next beat is accepted while an earlier result waits. The user writes
// configuration registers via cfg_we/cfg_addr/cfg_wdata only while idle; not enforced.
module fan_tach_rpm_meter (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [ftach_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ftach_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ftach_pkg::S_TDATA_W-1:0]       s_tdata,  // capture_value
    input  logic                                  s_tuser,  // opcode
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ftach_pkg::M_TDATA_W-1:0]       m_tdata,  // rpm, zero pad
    output logic                                  m_tuser   // stalled
);

    ftach_pkg::ftach_cmd_t          cmd;
    ftach_pkg::ftach_sts_t          sts;
    logic [ftach_pkg::RPM_W-1:0]    rpm;

    ftach_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ftach_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .opcode        (s_tuser),
        .capture_value (s_tdata),
        .cmd           (cmd),
        .sts           (sts),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .rpm           (rpm),
        .stalled       (m_tuser)
    );

    assign m_tdata = ftach_pkg::M_TDATA_W'(rpm);

endmodule
